// ===== rtl/core/srrip_pkg.sv =====
// Shared types, constants and helpers for the SRRIP set replacement block.
// No dependencies; every other file in rtl/core refers to this package.
package srrip_pkg;

	localparam int WAYS     = 16;
	localparam int WAY_W    = $clog2(WAYS);
	localparam int MASK_W   = 16;
	localparam int CTR_W    = 8;
	localparam int CFG_W    = 4;
	localparam int ATT_W    = 4;
	localparam int VICTIM_W = 4;
	localparam int USED_W   = 3;

	// configuration register indexes
	localparam logic REG_COUNTER_BITS = 1'b0;
	localparam logic REG_MAX_ATTEMPTS = 1'b1;

	// operation codes
	localparam logic OP_VICTIM = 1'b0;
	localparam logic OP_HIT    = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [3:0]        hit_way;
		logic [MASK_W-1:0] valid_ways;
		logic [MASK_W-1:0] lower_held_ways;
	} req_t;

	typedef struct packed {
		logic [VICTIM_W-1:0] victim_way;
		logic [USED_W-1:0]   attempts_used;
		logic [CTR_W-1:0]    prior_counter;
		logic                search_failed;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic do_hit;
		logic do_inv;
		logic do_scan;
		logic do_age;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic op_hit;
		logic any_inv;
		logic cand_max;
		logic reject;
		logic iter_last;
		logic pass_last;
	} status_t;

	// counter maximum; width is clamped to 1..8
	function automatic logic [CTR_W-1:0] rrpv_max(input logic [CFG_W-1:0] bits);
		logic [CFG_W-1:0] b;
		logic [CTR_W:0]   m;
		b = bits;
		if (b == '0) b = CFG_W'(1);
		if (b > CFG_W'(8)) b = CFG_W'(8);
		m = ((CTR_W+1)'(1) << b) - (CTR_W+1)'(1);
		return m[CTR_W-1:0];
	endfunction

	localparam logic [CTR_W-1:0] CTR_RESET = rrpv_max(CFG_W'(2)) - CTR_W'(1);

endpackage

// ===== rtl/core/srrip_ctrl.sv =====
// Controller state machine for the SRRIP set replacement block.
// Depends on srrip_pkg (cmd_t, status_t).
module srrip_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  srrip_pkg::status_t  st,
	output srrip_pkg::cmd_t     cmd,
	output logic                busy,
	output logic                done
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DISP = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_AGE  = 2'd3;

	logic [1:0] state_q, state_d;
	logic       done_q, fin;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		fin     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				if (st.op_hit) begin
					cmd.do_hit = 1'b1;
					fin        = 1'b1;
					state_d    = S_IDLE;
				end else if (st.any_inv) begin
					cmd.do_inv = 1'b1;
					fin        = 1'b1;
					state_d    = S_IDLE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.do_scan = 1'b1;
				if (st.cand_max && !st.reject) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else if (st.iter_last) begin
					state_d = S_AGE;
				end
			end
			S_AGE: begin
				cmd.do_age = 1'b1;
				if (st.pass_last) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_SCAN;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// ===== rtl/core/srrip_dp.sv =====
// Datapath of the SRRIP set replacement block: counters, pointer, config, result.
// Depends on srrip_pkg; driven by srrip_ctrl through cmd_t / status_t.
module srrip_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  srrip_pkg::cmd_t                   cmd,
	output srrip_pkg::status_t                st,
	input  srrip_pkg::req_t                   req,
	output srrip_pkg::rsp_t                   rsp,
	input  logic                              cfg_we,
	input  logic                              cfg_idx,
	input  logic [srrip_pkg::CFG_W-1:0]       cfg_data
);

	logic [srrip_pkg::CFG_W-1:0]   counter_bits_q, max_attempts_q;
	logic [srrip_pkg::CTR_W-1:0]   ctr_q [srrip_pkg::WAYS];
	logic [srrip_pkg::WAY_W-1:0]   ptr_q, iter_q, hw_idx, rd_idx, inv_idx, ptr_nx;
	logic [srrip_pkg::ATT_W-1:0]   att_q;
	logic [srrip_pkg::CTR_W-1:0]   pass_q, mx, ins, cur;
	logic [srrip_pkg::USED_W-1:0]  att_sat;
	logic [srrip_pkg::WAYS-1:0]    valid_x, lower_x;
	srrip_pkg::req_t               req_q;
	srrip_pkg::rsp_t               rsp_q, rsp_d;
	logic                          hw_ok, any_inv, cand_max, reject, rsp_we;

	assign mx  = srrip_pkg::rrpv_max(counter_bits_q);
	assign ins = mx - srrip_pkg::CTR_W'(1);

	// ways past the mask count as valid and not held below
	always_comb begin
		for (int w = 0; w < srrip_pkg::WAYS; w++) begin
			valid_x[w] = (w < srrip_pkg::MASK_W) ?
				req_q.valid_ways[w % srrip_pkg::MASK_W] : 1'b1;
			lower_x[w] = (w < srrip_pkg::MASK_W) ?
				req_q.lower_held_ways[w % srrip_pkg::MASK_W] : 1'b0;
		end
	end

	// lowest invalid way
	always_comb begin
		inv_idx = '0;
		any_inv = 1'b0;
		for (int w = srrip_pkg::WAYS - 1; w >= 0; w--) begin
			if (!valid_x[w]) begin
				inv_idx = srrip_pkg::WAY_W'(w);
				any_inv = 1'b1;
			end
		end
	end

	assign hw_ok  = (32'(req_q.hit_way) < srrip_pkg::WAYS);
	assign hw_idx = srrip_pkg::WAY_W'(req_q.hit_way);
	assign rd_idx = (req_q.operation == srrip_pkg::OP_HIT) ? hw_idx : ptr_q;
	assign cur    = ctr_q[rd_idx];

	assign cand_max = (cur >= mx);
	assign reject   = lower_x[ptr_q] &&
		(({1'b0, att_q} + (srrip_pkg::ATT_W+1)'(1)) < {1'b0, max_attempts_q});
	assign ptr_nx   = (32'(ptr_q) == srrip_pkg::WAYS - 1) ? '0 :
		ptr_q + srrip_pkg::WAY_W'(1);
	assign att_sat  = (att_q > srrip_pkg::ATT_W'(7)) ? srrip_pkg::USED_W'(7) :
		att_q[srrip_pkg::USED_W-1:0];

	assign st.op_hit    = (req_q.operation == srrip_pkg::OP_HIT);
	assign st.any_inv   = any_inv;
	assign st.cand_max  = cand_max;
	assign st.reject    = reject;
	assign st.iter_last = (32'(iter_q) == srrip_pkg::WAYS - 1);
	assign st.pass_last = (pass_q == mx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_bits_q <= srrip_pkg::CFG_W'(2);
			max_attempts_q <= srrip_pkg::CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				srrip_pkg::REG_COUNTER_BITS: counter_bits_q <= cfg_data;
				srrip_pkg::REG_MAX_ATTEMPTS: max_attempts_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < srrip_pkg::WAYS; w++) ctr_q[w] <= srrip_pkg::CTR_RESET;
		end else begin
			if (cmd.do_hit && hw_ok && cur != '0)
				ctr_q[hw_idx] <= cur - srrip_pkg::CTR_W'(1);
			if (cmd.do_inv)
				ctr_q[inv_idx] <= ins;
			if (cmd.do_scan && cand_max)
				ctr_q[ptr_q] <= reject ? '0 : ins;
			if (cmd.do_age) begin
				for (int w = 0; w < srrip_pkg::WAYS; w++)
					if (ctr_q[w] < mx) ctr_q[w] <= ctr_q[w] + srrip_pkg::CTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			iter_q <= '0;
			att_q  <= '0;
			pass_q <= '0;
		end else begin
			if (cmd.load) begin
				iter_q <= '0;
				att_q  <= '0;
				pass_q <= '0;
			end
			if (cmd.do_scan) begin
				iter_q <= iter_q + srrip_pkg::WAY_W'(1);
				if (cand_max && reject) att_q <= att_q + srrip_pkg::ATT_W'(1);
				else ptr_q <= ptr_nx;
			end
			if (cmd.do_age) begin
				iter_q <= '0;
				pass_q <= pass_q + srrip_pkg::CTR_W'(1);
			end
		end
	end

	// next result item; the controller fires at most one command per cycle
	always_comb begin
		rsp_d = '0;
		if (cmd.do_hit)
			rsp_d.prior_counter = hw_ok ? cur : '0;
		if (cmd.do_inv)
			rsp_d.victim_way = srrip_pkg::VICTIM_W'(inv_idx);
		if (cmd.do_scan) begin
			rsp_d.victim_way    = srrip_pkg::VICTIM_W'(ptr_q);
			rsp_d.attempts_used = att_sat;
		end
		if (cmd.do_age) begin
			rsp_d.attempts_used = att_sat;
			rsp_d.search_failed = 1'b1;
		end
	end

	assign rsp_we = cmd.do_hit || cmd.do_inv || (cmd.do_scan && cand_max && !reject) ||
		(cmd.do_age && st.pass_last);

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (rsp_we) rsp_q <= rsp_d;
	end

	assign rsp = rsp_q;

endmodule

// ===== rtl/core/srrip_set_replacement.sv =====
// Top level of the SRRIP set replacement block: controller plus datapath.
// Depends on srrip_pkg, srrip_ctrl and srrip_dp.
//
// Usage:
//   Command channel: drive req and pulse start while busy is low; the item is
//   taken at that clock edge and busy rises on the next cycle.
//   Result channel: done is high for exactly one cycle with rsp holding the
//   result; nothing can hold it off, so capture it in that cycle.
//   Config port: cfg_we with cfg_idx (0 = counter_bits, 1 = max_attempts) and
//   cfg_data writes a register at the edge; write only while the block is idle.
// Sequencing:
//   A hit, or a miss with an invalid way, ends in the dispatch state. A full
//   miss scans one way per cycle (a rejected held-below way is scanned again)
//   and ages all counters after each failed pass; it fails after max + 1
//   passes, max = 2^counter_bits - 1 with counter_bits clamped to 1..8.
//   busy drops in the cycle done is high, so the next item can start then.
// Reset:
//   arst_n clears the controller, sets every counter to 2 (maximum minus one
//   at the reset width), the pointer to way 0, and the registers to 2 and 1.
module srrip_set_replacement (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  srrip_pkg::req_t                req,
	output logic                           done,
	output srrip_pkg::rsp_t                rsp,
	input  logic                           cfg_we,
	input  logic                           cfg_idx,
	input  logic [srrip_pkg::CFG_W-1:0]    cfg_data
);

	srrip_pkg::cmd_t    cmd;
	srrip_pkg::status_t st;

	// sequence each item: dispatch, then on a full miss scan and age until a victim or failure
	srrip_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// hold counters, pointer and config; register the result item
	srrip_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.req      (req),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

endmodule

// ===== rtl/core/srrip_chk.sv =====
// Port-level checker for srrip_set_replacement, attached by bind.
// Depends on srrip_pkg (rsp_t) and the top level's ports.
module srrip_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            done,
	input srrip_pkg::rsp_t rsp
);

	// result cycle is also the cycle the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("two results in a row");

	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("busy dropped without a result");

	a_fail_way: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.search_failed |-> rsp.victim_way == '0)
		else $error("failed search reports a victim");

endmodule

bind srrip_set_replacement srrip_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
